FILE: src/matrix_multiply_unit_macros.svh
// assertion macros for the matrix multiply unit
`ifndef MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define MATRIX_MULTIPLY_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, clocked on clk, held off during reset
`define MMU_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, clocked on clk, held off during reset
`define MMU_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define MMU_ASSERT_IMP(name, ante, cons)
`define MMU_ASSERT_NXT(name, ante, cons)

`endif

`endif

FILE: src/mm_pkg.sv
package mm_pkg;

    localparam int MAX_DIM = 8;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int SUM_W   = 35;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
        mem_addr = ADDR_W'(int'(row) * MAX_DIM + int'(col));
    endfunction

    // register value 0 counts as 1, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        eff_dim = r;
    endfunction

endpackage

FILE: src/mm_ram.sv
module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/mm_mac.sv
module mm_mac import mm_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [ELEM_W-1:0] a,
    input  logic signed [ELEM_W-1:0] b,
    output logic signed [SUM_W-1:0]  sum,
    output logic                     done
);

    mac_ctl_t                 ctl2_reg;
    logic                     done_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;

    assign prod_next = a * b;

    always_comb
    begin
        acc_next = (ctl2_reg.first ? '0 : acc_reg)
                 + {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl2_reg <= ctl;
            done_reg <= ctl2_reg.valid & ctl2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prod_reg <= prod_next;
        end
        if (ctl2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign sum  = acc_reg;
    assign done = done_reg;

endmodule

FILE: src/matrix_multiply_unit.sv
// channel   direction  transfer contents
// s_*       in         cmd in tuser, element row/col/value in tdata
// m_*       out        product element in tdata, mismatch in tuser, tlast on final
// apb       in         dimension registers a_rows, a_cols, b_rows, b_cols
//
// a compute uses one shared multiply-accumulate unit, fed one term per cycle from
// single-port element memories, then waits for its pipeline to drain and takes an
// emit step for each result
// a dimension mismatch goes to the error step, which loads its single result once the output register is free
// s_tready is low from compute start until the final result is in the output register
// output stalls hold the sequencer in its emit or error step; rst_n clears control state only
`include "matrix_multiply_unit_macros.svh"

module matrix_multiply_unit import mm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // elem_row, elem_col, elem_value, zero pad
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // sum_value, out_row, out_col, zero pad
    output logic [0:0]  m_tuser,   // mismatch
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] CMD_WR_A    = 2'd0;
    localparam logic [1:0] CMD_WR_B    = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_ERR  = 3'd4;

    logic [DIM_W-1:0] a_rows_reg;
    logic [DIM_W-1:0] a_cols_reg;
    logic [DIM_W-1:0] b_rows_reg;
    logic [DIM_W-1:0] b_cols_reg;
    logic [DIM_W-1:0] ar_eff;
    logic [DIM_W-1:0] ac_eff;
    logic [DIM_W-1:0] br_eff;
    logic [DIM_W-1:0] bc_eff;
    logic             cfg_wr;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] j_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [DIM_W-1:0] i_ext;
    logic [DIM_W-1:0] j_ext;
    logic [DIM_W-1:0] k_ext;
    logic             last_i;
    logic             last_j;
    logic             last_k;

    logic              accept;
    logic [1:0]        in_cmd;
    logic [IDX_W-1:0]  in_row;
    logic [IDX_W-1:0]  in_col;
    logic [ELEM_W-1:0] in_value;
    logic              in_range;
    logic              a_we;
    logic              b_we;
    logic [ADDR_W-1:0] load_addr;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [ELEM_W-1:0] a_q;
    logic [ELEM_W-1:0] b_q;

    mac_ctl_t          ctl_reg;
    mac_ctl_t          ctl_next;
    logic [SUM_W-1:0]  mac_sum;
    logic              mac_done;

    logic              out_free;
    logic              load_res;
    logic              load_err;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SUM_W-1:0]  out_sum_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic              out_mis_reg;
    logic              out_last_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_W'(1);
            a_cols_reg <= DIM_W'(1);
            b_rows_reg <= DIM_W'(1);
            b_cols_reg <= DIM_W'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_A_ROWS: a_rows_reg <= pwdata[DIM_W-1:0];
                REG_A_COLS: a_cols_reg <= pwdata[DIM_W-1:0];
                REG_B_ROWS: b_rows_reg <= pwdata[DIM_W-1:0];
                REG_B_COLS: b_cols_reg <= pwdata[DIM_W-1:0];
                default:    a_rows_reg <= a_rows_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_A_ROWS: prdata = 32'(a_rows_reg);
            REG_A_COLS: prdata = 32'(a_cols_reg);
            REG_B_ROWS: prdata = 32'(b_rows_reg);
            REG_B_COLS: prdata = 32'(b_cols_reg);
            default:    prdata = '0;
        endcase
    end

    assign ar_eff = eff_dim(a_rows_reg);
    assign ac_eff = eff_dim(a_cols_reg);
    assign br_eff = eff_dim(b_rows_reg);
    assign bc_eff = eff_dim(b_cols_reg);

    // input side
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign in_cmd   = s_tuser;
    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[21:6];
    assign in_range = (DIM_W'(in_row) < DIM_W'(MAX_DIM)) && (DIM_W'(in_col) < DIM_W'(MAX_DIM));
    assign a_we     = accept && (in_cmd == CMD_WR_A) && in_range;
    assign b_we     = accept && (in_cmd == CMD_WR_B) && in_range;

    assign load_addr = mem_addr(in_row, in_col);
    assign a_addr    = (state_reg == ST_IDLE) ? load_addr : mem_addr(i_reg, k_reg);
    assign b_addr    = (state_reg == ST_IDLE) ? load_addr : mem_addr(k_reg, j_reg);

    mm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk   (clk),
        .wr_en (a_we),
        .addr  (a_addr),
        .wdata (in_value),
        .rdata (a_q)
    );

    mm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk   (clk),
        .wr_en (b_we),
        .addr  (b_addr),
        .wdata (in_value),
        .rdata (b_q)
    );

    // sequencer
    assign i_ext  = DIM_W'(i_reg);
    assign j_ext  = DIM_W'(j_reg);
    assign k_ext  = DIM_W'(k_reg);
    assign last_i = (i_ext == ar_eff - DIM_W'(1));
    assign last_j = (j_ext == bc_eff - DIM_W'(1));
    assign last_k = (k_ext == ac_eff - DIM_W'(1));

    assign out_free = !out_valid_reg || m_tready;
    assign load_res = (state_reg == ST_EMIT) && out_free;
    assign load_err = (state_reg == ST_ERR) && out_free;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_cmd == CMD_COMPUTE))
                begin
                    i_next = '0;
                    j_next = '0;
                    k_next = '0;
                    state_next = (ac_eff != br_eff) ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (last_j)
                    begin
                        j_next = '0;
                        if (last_i)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = ST_RUN;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = ST_RUN;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl_next.valid = (state_reg == ST_RUN);
        ctl_next.first = (k_reg == '0);
        ctl_next.last  = last_k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            ctl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            ctl_reg   <= ctl_next;
        end
    end

    mm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_reg),
        .a     (a_q),
        .b     (b_q),
        .sum   (mac_sum),
        .done  (mac_done)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_res || load_err)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            out_sum_reg  <= mac_sum;
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_mis_reg  <= 1'b0;
            out_last_reg <= last_i && last_j;
        end
        else if (load_err)
        begin
            out_sum_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_mis_reg  <= 1'b1;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_col_reg, out_row_reg, out_sum_reg};
    assign m_tuser  = out_mis_reg;
    assign m_tlast  = out_last_reg;

    `MMU_ASSERT_IMP(a_done_in_wait, mac_done, state_reg == ST_WAIT)
    `MMU_ASSERT_IMP(a_no_write_busy, a_we || b_we, state_reg == ST_IDLE)
    `MMU_ASSERT_IMP(a_k_in_range, state_reg == ST_RUN, k_ext < ac_eff)
    `MMU_ASSERT_NXT(a_err_emits, load_err, m_tvalid && m_tuser[0] && m_tlast && (m_tdata == '0))

endmodule

FILE: tb/matrix_multiply_unit_tb.sv
module matrix_multiply_unit_tb import mm_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        CMD_LOAD_A   = 2'd0,
        CMD_LOAD_B   = 2'd1,
        CMD_MULTIPLY = 2'd2,
        CMD_IDLE     = 2'd3
    } mm_cmd_e;

    localparam int REG_A_ROWS = 0;
    localparam int REG_A_COLS = 1;
    localparam int REG_B_ROWS = 2;
    localparam int REG_B_COLS = 3;

    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 220;

    typedef struct {
        mm_cmd_e     cmd;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [15:0] value;
    } mm_item_t;

    typedef struct {
        logic [34:0] sum;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        mismatch;
        logic        last;
    } mm_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // elem_row, elem_col, elem_value, zero pad
    logic [1:0]  s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // sum_value, out_row, out_col, zero pad
    logic [0:0]  m_tuser;   // mismatch
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    matrix_multiply_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mm_item_t   elem_cmd_q[$];
    mm_result_t product_q[$];

    // predictor state
    logic [3:0]         dim_reg [4];
    logic signed [15:0] mat_a [64];
    logic signed [15:0] mat_b [64];

    // stimulus-side record of which elements were loaded
    bit gen_a_set [64];
    bit gen_b_set [64];

    int  pushed_cnt;
    int  accepted_cnt;
    int  item_cnt;
    int  err_cnt;
    int  quiet_cycles;
    int  send_gap;
    int  recv_stall;
    bit  idle_on;
    bit  s_xfer;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic int dim_of(input logic [3:0] v);
        if (v == 4'd0)
        begin
            return 1;
        end
        if (int'(v) > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    task automatic predict_product(input mm_cmd_e cmd, input logic [2:0] row,
                                   input logic [2:0] col, input logic [15:0] value);
        int ar;
        int ac;
        int br;
        int bc;
        logic signed [63:0] acc;
        mm_result_t r;
        ar = dim_of(dim_reg[REG_A_ROWS]);
        ac = dim_of(dim_reg[REG_A_COLS]);
        br = dim_of(dim_reg[REG_B_ROWS]);
        bc = dim_of(dim_reg[REG_B_COLS]);
        case (cmd)
            CMD_LOAD_A: mat_a[row * MAX_DIM + col] = value;
            CMD_LOAD_B: mat_b[row * MAX_DIM + col] = value;
            CMD_MULTIPLY:
            begin
                if (ac != br)
                begin
                    r.sum = '0;
                    r.row = '0;
                    r.col = '0;
                    r.mismatch = 1'b1;
                    r.last = 1'b1;
                    product_q.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < ar; i++)
                    begin
                        for (int j = 0; j < bc; j++)
                        begin
                            acc = '0;
                            for (int k = 0; k < ac; k++)
                            begin
                                acc += 64'(mat_a[i * MAX_DIM + k]) *
                                       64'(mat_b[k * MAX_DIM + j]);
                            end
                            r.sum = acc[34:0];
                            r.row = 3'(i);
                            r.col = 3'(j);
                            r.mismatch = 1'b0;
                            r.last = (i == ar - 1) && (j == bc - 1);
                            product_q.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_product(input logic [47:0] data, input logic flag,
                                 input logic lst);
        mm_result_t want;
        if (product_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
                     $time, data, flag, lst);
            err_cnt++;
        end
        else
        begin
            want = product_q.pop_front();
            if (data[34:0] !== want.sum)
            begin
                $display("%0t: sum_value expected %h actual %h", $time, want.sum, data[34:0]);
                err_cnt++;
            end
            if (data[37:35] !== want.row)
            begin
                $display("%0t: out_row expected %0d actual %0d", $time, want.row, data[37:35]);
                err_cnt++;
            end
            if (data[40:38] !== want.col)
            begin
                $display("%0t: out_col expected %0d actual %0d", $time, want.col, data[40:38]);
                err_cnt++;
            end
            if (flag !== want.mismatch)
            begin
                $display("%0t: mismatch expected %b actual %b", $time, want.mismatch, flag);
                err_cnt++;
            end
            if (lst !== want.last)
            begin
                $display("%0t: last expected %b actual %b", $time, want.last, lst);
                err_cnt++;
            end
        end
    endtask

    // monitor, predictor and watchdog count
    always @(posedge clk)
    begin
        s_xfer = rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            check_product(m_tdata, m_tuser[0], m_tlast);
        end
        if (s_xfer)
        begin
            predict_product(mm_cmd_e'(s_tuser), s_tdata[2:0], s_tdata[5:3], s_tdata[21:6]);
            accepted_cnt++;
        end
        if (s_xfer || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
    end

    // element and command driver
    always @(negedge clk)
    begin
        mm_item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_xfer)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (elem_cmd_q.size() > 0)
            begin
                it = elem_cmd_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= it.cmd;
                s_tdata <= {2'b00, it.value, it.col, it.row};
                if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(1, 10);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(negedge clk)
    begin
        if (recv_stall > 0)
        begin
            recv_stall--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                recv_stall = $urandom_range(1, 10);
            end
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("simulation failed");
        $finish;
    end

    task automatic write_dim(input int idx, input logic [3:0] v);
        logic [31:0] word;
        word = {$urandom_range(0, 1) ? 28'($urandom) : 28'd0, v};
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx * 4);
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        dim_reg[idx] = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[3:0] !== v)
        begin
            $display("%0t: register %0d readback expected %h actual %h", $time, idx, v,
                     prdata[3:0]);
            err_cnt++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_dims(input logic [3:0] ar, input logic [3:0] ac,
                            input logic [3:0] br, input logic [3:0] bc);
        write_dim(REG_A_ROWS, ar);
        write_dim(REG_A_COLS, ac);
        write_dim(REG_B_ROWS, br);
        write_dim(REG_B_COLS, bc);
    endtask

    task automatic push_item(input mm_cmd_e cmd, input logic [2:0] row,
                             input logic [2:0] col, input logic [15:0] value);
        mm_item_t it;
        it.cmd = cmd;
        it.row = row;
        it.col = col;
        it.value = value;
        elem_cmd_q.push_back(it);
        pushed_cnt++;
        if (cmd != CMD_IDLE)
        begin
            item_cnt++;
        end
        if (cmd == CMD_LOAD_A)
        begin
            gen_a_set[row * MAX_DIM + col] = 1'b1;
        end
        if (cmd == CMD_LOAD_B)
        begin
            gen_b_set[row * MAX_DIM + col] = 1'b1;
        end
    endtask

    function automatic logic [15:0] pick_elem();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // loads unloaded elements the product reads when dimensions agree, then multiplies
    task automatic push_multiply();
        int ar;
        int ac;
        int bc;
        ar = dim_of(dim_reg[REG_A_ROWS]);
        ac = dim_of(dim_reg[REG_A_COLS]);
        bc = dim_of(dim_reg[REG_B_COLS]);
        if (ac == dim_of(dim_reg[REG_B_ROWS]))
        begin
            for (int i = 0; i < ar; i++)
            begin
                for (int k = 0; k < ac; k++)
                begin
                    if (!gen_a_set[i * MAX_DIM + k])
                    begin
                        push_item(CMD_LOAD_A, 3'(i), 3'(k), pick_elem());
                    end
                end
            end
            for (int k = 0; k < ac; k++)
            begin
                for (int j = 0; j < bc; j++)
                begin
                    if (!gen_b_set[k * MAX_DIM + j])
                    begin
                        push_item(CMD_LOAD_B, 3'(k), 3'(j), pick_elem());
                    end
                end
            end
        end
        push_item(CMD_MULTIPLY, 3'($urandom), 3'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        while (!(accepted_cnt == pushed_cnt && product_q.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [3:0] pick_dim_reg();
        case ($urandom_range(0, 11))
            0: return 4'd0;
            1: return 4'($urandom_range(9, 15));
            2: return 4'd8;
            3: return 4'($urandom_range(5, 7));
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    // an encoding with the same effective dimension, randomised where several exist
    function automatic logic [3:0] alias_dim(input logic [3:0] v);
        int d;
        d = dim_of(v);
        if (d == 1)
        begin
            return $urandom_range(0, 1) ? 4'd0 : 4'd1;
        end
        if (d == MAX_DIM)
        begin
            return 4'($urandom_range(8, 15));
        end
        return 4'(d);
    endfunction

    initial
    begin
        logic [3:0] ar;
        logic [3:0] ac;
        logic [3:0] br;
        logic [3:0] bc;
        int steps;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < 4; i++)
        begin
            dim_reg[i] = 4'd1;
        end
        for (int i = 0; i < 64; i++)
        begin
            mat_a[i] = '0;
            mat_b[i] = '0;
            gen_a_set[i] = 1'b0;
            gen_b_set[i] = 1'b0;
        end
        idle_on = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one by one with reset dimensions
        push_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h7fff);
        push_item(CMD_LOAD_B, 3'd0, 3'd0, 16'h7fff);
        push_item(CMD_MULTIPLY, 3'd0, 3'd0, 16'h0000);
        push_item(CMD_LOAD_A, 3'd0, 3'd0, 16'h8000);
        push_item(CMD_LOAD_B, 3'd0, 3'd0, 16'h8000);
        push_item(CMD_MULTIPLY, 3'd7, 3'd7, 16'hffff);
        push_item(CMD_LOAD_A, 3'd7, 3'd7, 16'hffff);
        push_item(CMD_LOAD_B, 3'd7, 3'd7, 16'h0001);
        push_item(CMD_IDLE, 3'd5, 3'd2, 16'ha5a5);
        drain();

        // row by column at full depth, register values out of range, largest sum
        set_dims(4'd0, 4'd15, 4'd8, 4'd0);
        for (int k = 0; k < MAX_DIM; k++)
        begin
            push_item(CMD_LOAD_A, 3'd0, 3'(k), 16'h8000);
            push_item(CMD_LOAD_B, 3'(k), 3'd0, 16'h8000);
        end
        push_item(CMD_MULTIPLY, 3'd3, 3'd6, 16'h1234);
        drain();

        // inner dimensions disagree
        set_dims(4'd2, 4'd3, 4'd2, 4'd2);
        push_item(CMD_MULTIPLY, 3'd0, 3'd0, 16'h0000);
        drain();

        while (item_cnt < RANDOM_ITEMS)
        begin
            idle_on = (item_cnt < RANDOM_ITEMS - 40);
            ar = pick_dim_reg();
            ac = pick_dim_reg();
            bc = pick_dim_reg();
            if ($urandom_range(0, 6) == 0)
            begin
                br = pick_dim_reg();
            end
            else
            begin
                br = alias_dim(ac);
            end
            set_dims(ar, ac, br, bc);
            steps = $urandom_range(3, 12);
            for (int s = 0; s < steps; s++)
            begin
                case ($urandom_range(0, 7))
                    0, 1: push_item(CMD_LOAD_A, 3'($urandom), 3'($urandom), pick_elem());
                    2, 3: push_item(CMD_LOAD_B, 3'($urandom), 3'($urandom), pick_elem());
                    4, 5: push_multiply();
                    6: push_item(CMD_IDLE, 3'($urandom), 3'($urandom), 16'($urandom));
                    default:
                    begin
                        // overwrite a run of A elements in place
                        for (int k = 0; k < dim_of(ac); k++)
                        begin
                            push_item(CMD_LOAD_A, 3'($urandom_range(0, dim_of(ar) - 1)),
                                      3'(k), pick_elem());
                        end
                    end
                endcase
            end
            push_multiply();
            drain();
        end

        while (!(accepted_cnt == pushed_cnt && product_q.size() == 0))
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/mm_pkg.sv
src/mm_ram.sv
src/mm_mac.sv
src/matrix_multiply_unit.sv
tb/matrix_multiply_unit_tb.sv
